[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LAST  = 8'h7F;

  localparam logic [15:0] RESET_CELL = 16'h0F20;
  localparam logic [3:0]  RESET_BG   = 4'h0;
  localparam logic [3:0]  RESET_FG   = 4'hF;

  localparam logic REG_BG = 1'b0;
  localparam logic REG_FG = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [15:0] cell_word;
    logic        did_scroll;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT_PRINT,
    OP_PUT_BS,
    OP_PUT_TAB,
    OP_PUT_CR,
    OP_PUT_NL,
    OP_CLEAR,
    OP_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

[src/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input words and decodes them into back-end commands.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcw_pkg::in_word_t     in_data,
  input  tcw_pkg::back_status_t status,
  input  logic                  q_full,
  output logic                  push,
  output tcw_pkg::cmd_t         push_cmd
);

  assign in_ready = !q_full && !status.init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_cmd.op         = tcw_pkg::OP_NOP;
    push_cmd.char_code  = in_data.char_code;
    push_cmd.cell_index = in_data.cell_index;
    case (in_data.func)
      tcw_pkg::FUNC_PUT: begin
        if (in_data.char_code == tcw_pkg::CHAR_BS) begin
          push_cmd.op = tcw_pkg::OP_PUT_BS;
        end else if (in_data.char_code == tcw_pkg::CHAR_TAB) begin
          push_cmd.op = tcw_pkg::OP_PUT_TAB;
        end else if (in_data.char_code == tcw_pkg::CHAR_CR) begin
          push_cmd.op = tcw_pkg::OP_PUT_CR;
        end else if (in_data.char_code == tcw_pkg::CHAR_NL) begin
          push_cmd.op = tcw_pkg::OP_PUT_NL;
        end else if (in_data.char_code >= tcw_pkg::CHAR_SPACE &&
                     in_data.char_code <= tcw_pkg::CHAR_LAST) begin
          push_cmd.op = tcw_pkg::OP_PUT_PRINT;
        end
      end
      tcw_pkg::FUNC_CLEAR: begin
        push_cmd.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::FUNC_READ: begin
        if (32'(in_data.cell_index) < CELLS) begin
          push_cmd.op = tcw_pkg::OP_READ;
        end
      end
      default: begin
        push_cmd.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

[src/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output tcw_pkg::cmd_t q_cmd
);

  tcw_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands: owns the screen memory, the cursor and the result
// register; runs the reset fill, clear, scroll and read sequences.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            attr,
  input  logic                  q_valid,
  input  tcw_pkg::cmd_t         q_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tcw_pkg::out_word_t    out_data,
  output tcw_pkg::back_status_t status
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLS);
  localparam int CW    = $clog2(COLS + TAB_STOP);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = $clog2(TAB_STOP);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LEN  = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_COPY  = 6'b010000,
    ST_BLANK = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [PW-1:0]  ph_r, ph_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic           out_valid_r, out_valid_nxt;
  tcw_pkg::out_word_t out_data_r, out_data_nxt;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  logic [CLW-1:0] put_col;
  logic [PW-1:0]  put_ph;
  logic [RW-1:0]  put_row;
  logic [AW-1:0]  put_base;
  logic           put_scroll;
  logic [AW-1:0]  loc_cur;
  logic [AW-1:0]  loc_put;
  logic [15:0]    blank;
  logic           is_put;

  assign loc_cur          = base_r + AW'(col_r);
  assign loc_put          = put_base + AW'(put_col);
  assign blank            = {attr, tcw_pkg::CHAR_SPACE};
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.init_busy = (state_r == ST_INIT);

  assign is_put = (q_cmd.op == tcw_pkg::OP_PUT_PRINT) || (q_cmd.op == tcw_pkg::OP_PUT_BS) ||
                  (q_cmd.op == tcw_pkg::OP_PUT_TAB) || (q_cmd.op == tcw_pkg::OP_PUT_CR) ||
                  (q_cmd.op == tcw_pkg::OP_PUT_NL);

  // cursor update for a put
  always_comb begin
    logic [CW-1:0] c;
    logic [PW-1:0] p;
    logic          adv;
    c   = CW'(col_r);
    p   = ph_r;
    adv = 1'b0;
    case (q_cmd.op)
      tcw_pkg::OP_PUT_BS: begin
        if (col_r != '0) begin
          c = CW'(col_r) - CW'(1);
          p = (ph_r == '0) ? PW'(TAB_STOP - 1) : ph_r - PW'(1);
        end
      end
      tcw_pkg::OP_PUT_TAB: begin
        c = CW'(col_r) + (CW'(TAB_STOP) - CW'(ph_r));
        p = '0;
      end
      tcw_pkg::OP_PUT_CR: begin
        c = '0;
        p = '0;
      end
      tcw_pkg::OP_PUT_NL: begin
        c   = '0;
        p   = '0;
        adv = 1'b1;
      end
      tcw_pkg::OP_PUT_PRINT: begin
        c = CW'(col_r) + CW'(1);
        p = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + PW'(1);
      end
      default: begin
        c = CW'(col_r);
      end
    endcase
    if (32'(c) >= COLS) begin
      c   = '0;
      p   = '0;
      adv = 1'b1;
    end
    put_col    = c[CLW-1:0];
    put_ph     = p;
    put_row    = row_r;
    put_base   = base_r;
    put_scroll = 1'b0;
    if (adv) begin
      if (row_r == RW'(ROWS - 1)) begin
        put_scroll = 1'b1;
      end else begin
        put_row  = row_r + RW'(1);
        put_base = base_r + ROW_STEP;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    ph_nxt        = ph_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = blank;
    raddr         = cnt_r + ROW_STEP;
    case (state_r)
      ST_INIT: begin
        we    = 1'b1;
        wdata = tcw_pkg::RESET_CELL;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          pop = 1'b1;
          if (is_put) begin
            col_nxt  = put_col;
            ph_nxt   = put_ph;
            row_nxt  = put_row;
            base_nxt = put_base;
            if (q_cmd.op == tcw_pkg::OP_PUT_PRINT) begin
              we    = 1'b1;
              waddr = loc_cur;
              wdata = {attr, q_cmd.char_code};
            end
            if (put_scroll) begin
              state_nxt = ST_COPY;
              cnt_nxt   = '0;
            end else begin
              out_valid_nxt                = 1'b1;
              out_data_nxt.cursor_location = 11'(loc_put);
              out_data_nxt.cell_word       = '0;
              out_data_nxt.did_scroll      = 1'b0;
            end
          end else if (q_cmd.op == tcw_pkg::OP_CLEAR) begin
            state_nxt = ST_FILL;
            cnt_nxt   = '0;
            col_nxt   = '0;
            ph_nxt    = '0;
            row_nxt   = '0;
            base_nxt  = '0;
          end else if (q_cmd.op == tcw_pkg::OP_READ) begin
            raddr     = AW'(q_cmd.cell_index);
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt                = 1'b1;
            out_data_nxt.cursor_location = 11'(loc_cur);
            out_data_nxt.cell_word       = '0;
            out_data_nxt.did_scroll      = 1'b0;
          end
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt                    = ST_IDLE;
          cnt_nxt                      = '0;
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_location = 11'(loc_cur);
          out_data_nxt.cell_word       = '0;
          out_data_nxt.did_scroll      = 1'b0;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_READ: begin
        state_nxt                    = ST_IDLE;
        out_valid_nxt                = 1'b1;
        out_data_nxt.cursor_location = 11'(loc_cur);
        out_data_nxt.cell_word       = rdata_r;
        out_data_nxt.did_scroll      = 1'b0;
      end
      ST_COPY: begin
        // read cell cnt+COLS, write the previous read back one row up
        waddr = cnt_r - AW'(1);
        wdata = rdata_r;
        we    = (cnt_r != '0);
        if (cnt_r == COPY_LEN) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_BLANK: begin
        we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt                    = ST_IDLE;
          cnt_nxt                      = '0;
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_location = 11'(loc_cur);
          out_data_nxt.cell_word       = '0;
          out_data_nxt.did_scroll      = 1'b1;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      ph_r        <= '0;
      row_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      ph_r        <= ph_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[src/text_console_character_writer.sv]
// ----------------------------------------------------------------------------
// text_console_character_writer
// Text-mode console: screen cell memory, cursor, color registers.
// ----------------------------------------------------------------------------
// Clear, scroll and the reset fill walk the screen memory one cell per
// cycle. Input: one word per cycle into the two-entry queue while it is not
// full and the reset fill is done; the back end runs one command at a time
// and takes the next only when its result register is empty or being read.
// Reset: synchronous active low; a fill pass writes every cell to 0x0F20,
// with in_ready low until it completes.
module text_console_character_writer #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0] bg_r, bg_nxt;
  logic [3:0] fg_r, fg_nxt;
  logic       cfg_wr;

  tcw_pkg::back_status_t status;
  tcw_pkg::cmd_t         push_cmd;
  tcw_pkg::cmd_t         q_cmd;
  logic                  push, q_full, pop, q_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tcw_pkg::REG_FG) ? {28'd0, fg_r} : {28'd0, bg_r};

  always_comb begin
    bg_nxt = bg_r;
    fg_nxt = fg_r;
    if (cfg_wr) begin
      if (paddr[2] == tcw_pkg::REG_BG) begin
        bg_nxt = pwdata[3:0];
      end else begin
        fg_nxt = pwdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= tcw_pkg::RESET_BG;
      fg_r <= tcw_pkg::RESET_FG;
    end else begin
      bg_r <= bg_nxt;
      fg_r <= fg_nxt;
    end
  end

  tcw_front #(
    .CELLS (SCREEN_COLUMNS * SCREEN_ROWS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tcw_back #(
    .COLS     (SCREEN_COLUMNS),
    .ROWS     (SCREEN_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      ({bg_r, fg_r}),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

[tb/text_console_character_writer_test.sv]
// ----------------------------------------------------------------------------
// text_console_character_writer_test
// Drives put, clear, read and unused-function words into the console with
// random content and random valid/ready gaps, tracks the screen, cursor and
// color registers in a shadow copy, and compares every result word field by
// field against the shadow prediction.
// ----------------------------------------------------------------------------
module text_console_character_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int TAB_WIDTH     = 4;
  localparam int CELL_COUNT    = SCREEN_COLS * SCREEN_ROWS;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tcw_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tcw_pkg::out_word_t out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcw_pkg::in_word_t  pending_words[$];
  tcw_pkg::out_word_t expected_results[$];
  int words_queued = 0;
  int words_accepted = 0;
  int error_count = 0;
  logic in_taken = 1'b0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_enable = 1'b0;
  int hold_count = 0;

  // shadow console state
  logic [15:0] shadow_screen [CELL_COUNT];
  int cursor_col = 0;
  int cursor_row = 0;
  logic [3:0] attr_bg = tcw_pkg::RESET_BG;
  logic [3:0] attr_fg = tcw_pkg::RESET_FG;

  text_console_character_writer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic tcw_pkg::out_word_t console_apply(tcw_pkg::in_word_t w);
    tcw_pkg::out_word_t r;
    logic [15:0] blank;
    int i;
    r = '0;
    blank = {attr_bg, attr_fg, tcw_pkg::CHAR_SPACE};
    if (w.func == tcw_pkg::FUNC_PUT) begin
      if (w.char_code == tcw_pkg::CHAR_BS) begin
        if (cursor_col != 0) cursor_col--;
      end else if (w.char_code == tcw_pkg::CHAR_TAB) begin
        cursor_col = cursor_col + TAB_WIDTH - (cursor_col % TAB_WIDTH);
      end else if (w.char_code == tcw_pkg::CHAR_CR) begin
        cursor_col = 0;
      end else if (w.char_code == tcw_pkg::CHAR_NL) begin
        cursor_col = 0;
        cursor_row++;
      end else if (w.char_code >= tcw_pkg::CHAR_SPACE &&
                   w.char_code <= tcw_pkg::CHAR_LAST) begin
        shadow_screen[cursor_row * SCREEN_COLS + cursor_col] = {attr_bg, attr_fg, w.char_code};
        cursor_col++;
      end
      if (cursor_col >= SCREEN_COLS) begin
        cursor_col = 0;
        cursor_row++;
      end
      if (cursor_row >= SCREEN_ROWS) begin
        for (i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
          shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
        for (i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < CELL_COUNT; i++)
          shadow_screen[i] = blank;
        cursor_row = SCREEN_ROWS - 1;
        r.did_scroll = 1'b1;
      end
    end else if (w.func == tcw_pkg::FUNC_CLEAR) begin
      for (i = 0; i < CELL_COUNT; i++) shadow_screen[i] = blank;
      cursor_col = 0;
      cursor_row = 0;
    end else if (w.func == tcw_pkg::FUNC_READ) begin
      if (w.cell_index < CELL_COUNT) r.cell_word = shadow_screen[w.cell_index];
    end
    r.cursor_location = 11'(cursor_row * SCREEN_COLS + cursor_col);
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with an optional long hold-off at the start of a phase
  always @(negedge clk) begin
    if (hold_enable && hold_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!hold_enable) hold_count <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    tcw_pkg::out_word_t want;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(console_apply(in_data));
      words_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.cursor_location !== want.cursor_location) begin
          $error("cursor_location: expected %0d, got %0d",
                 want.cursor_location, out_data.cursor_location);
          error_count++;
        end
        if (out_data.cell_word !== want.cell_word) begin
          $error("cell_word: expected %h, got %h", want.cell_word, out_data.cell_word);
          error_count++;
        end
        if (out_data.did_scroll !== want.did_scroll) begin
          $error("did_scroll: expected %b, got %b", want.did_scroll, out_data.did_scroll);
          error_count++;
        end
      end
    end
  end

  function automatic tcw_pkg::in_word_t make_word(logic [1:0] f, logic [7:0] c,
                                                  logic [10:0] idx);
    tcw_pkg::in_word_t w;
    w.func = f;
    w.char_code = c;
    w.cell_index = idx;
    return w;
  endfunction

  function automatic tcw_pkg::in_word_t random_word();
    tcw_pkg::in_word_t w;
    int pick;
    w.func = tcw_pkg::FUNC_PUT;
    w.char_code = 8'($urandom());
    w.cell_index = 11'($urandom());
    pick = $urandom_range(999);
    if (pick < 480) w.char_code = 8'($urandom_range(tcw_pkg::CHAR_LAST, tcw_pkg::CHAR_SPACE));
    else if (pick < 560) w.char_code = tcw_pkg::CHAR_NL;
    else if (pick < 600) w.char_code = tcw_pkg::CHAR_TAB;
    else if (pick < 630) w.char_code = tcw_pkg::CHAR_BS;
    else if (pick < 650) w.char_code = tcw_pkg::CHAR_CR;
    else if (pick < 670) w.char_code = 8'($urandom_range(31, 0));
    else if (pick < 700) w.char_code = 8'($urandom_range(255, 128));
    else if (pick < 960) begin
      w.func = tcw_pkg::FUNC_READ;
      if (pick < 950) w.cell_index = 11'($urandom_range(CELL_COUNT - 1));
      else w.cell_index = 11'($urandom_range(2047, CELL_COUNT));
    end else if (pick < 998) w.func = FUNC_UNUSED;
    else w.func = tcw_pkg::FUNC_CLEAR;
    return w;
  endfunction

  task automatic queue_word(tcw_pkg::in_word_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    int waited = 0;
    while ((words_accepted != words_queued || expected_results.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      $error("%0d result words still outstanding", expected_results.size());
      error_count++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_color(logic reg_sel, logic [3:0] color);
    logic [31:0] value;
    value = ($urandom() & 32'hFFFF_FFF0) | {28'd0, color};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == tcw_pkg::REG_BG) attr_bg = value[3:0];
    else attr_fg = value[3:0];
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct, bit hold, bit pause_midway);
    int n;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    hold_enable = hold;
    for (n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drained();
      queue_word(random_word());
    end
    wait_drained();
    hold_enable = 1'b0;
  endtask

  initial begin
    #160ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) shadow_screen[i] = tcw_pkg::RESET_CELL;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    // wait out the power-on fill of the screen memory
    do @(negedge clk); while (!in_ready);

    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'hFF, 11'd1999));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd2000));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'h7FF));
    queue_word(make_word(FUNC_UNUSED, 8'hFF, 11'h7FF));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'h41, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_SPACE, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_LAST, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'h80, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'hFF, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'h00, 11'h7FF));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'h1F, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BS, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_CR, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_BS, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, 8'h42, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_TAB, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NL, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd1));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd4));
    queue_word(make_word(tcw_pkg::FUNC_CLEAR, 8'h00, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd0));
    queue_word(make_word(tcw_pkg::FUNC_READ, 8'h00, 11'd80));
    wait_drained();

    write_color(tcw_pkg::REG_BG, 4'h0);
    write_color(tcw_pkg::REG_FG, 4'h0);
    run_phase(300, 0, 0, 1'b0, 1'b0);

    write_color(tcw_pkg::REG_BG, 4'hF);
    write_color(tcw_pkg::REG_FG, 4'hF);
    run_phase(300, 67, 0, 1'b0, 1'b0);

    write_color(tcw_pkg::REG_FG, 4'h0);
    run_phase(300, 0, 67, 1'b0, 1'b0);

    write_color(tcw_pkg::REG_BG, 4'($urandom_range(15)));
    write_color(tcw_pkg::REG_FG, 4'($urandom_range(15)));
    run_phase(300, 7, 7, 1'b0, 1'b0);

    // receiver holds off while the sender keeps offering; sender pauses midway
    write_color(tcw_pkg::REG_BG, 4'($urandom_range(15)));
    write_color(tcw_pkg::REG_FG, 4'($urandom_range(15)));
    run_phase(300, 0, 0, 1'b1, 1'b1);

    write_color(tcw_pkg::REG_BG, tcw_pkg::RESET_BG);
    write_color(tcw_pkg::REG_FG, tcw_pkg::RESET_FG);
    run_phase(225, $urandom_range(67), $urandom_range(67), 1'b0, 1'b0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_character_writer.sv
tb/text_console_character_writer_test.sv
